// ===== hdl/irc_format_to_ansi_escape_assert.svh =====
`ifndef IRC_FORMAT_TO_ANSI_ESCAPE_ASSERT_SVH
`define IRC_FORMAT_TO_ANSI_ESCAPE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/irc_fmt_pkg.sv =====
package irc_fmt_pkg;

    // Input and result payloads
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } irc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } irc_out_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_PLAIN    = 3'd0,
        PH_COLOR    = 3'd1,
        PH_FG1      = 3'd2,
        PH_AFTER_FG = 3'd3,
        PH_COMMA    = 3'd4,
        PH_BG1      = 3'd5
    } phase_t;

    // Control characters of the chat format
    localparam logic [7:0] CH_BOLD      = 8'h02;
    localparam logic [7:0] CH_COLOR     = 8'h03;
    localparam logic [7:0] CH_RESET     = 8'h0F;
    localparam logic [7:0] CH_REVERSE   = 8'h16;
    localparam logic [7:0] CH_ITALIC    = 8'h1D;
    localparam logic [7:0] CH_UNDERLINE = 8'h1F;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DIGIT0    = 8'h30;
    localparam logic [7:0] CH_DIGIT1    = 8'h31;
    localparam logic [7:0] CH_DIGIT3    = 8'h33;
    localparam logic [7:0] CH_DIGIT4    = 8'h34;
    localparam logic [7:0] CH_DIGIT9    = 8'h39;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_M         = 8'h6D;

    // SGR parameter values
    localparam logic [6:0] SGR_BOLD          = 7'd1;
    localparam logic [6:0] SGR_ITALIC        = 7'd3;
    localparam logic [6:0] SGR_UNDERLINE     = 7'd4;
    localparam logic [6:0] SGR_REVERSE       = 7'd7;
    localparam logic [6:0] SGR_BOLD_OFF      = 7'd22;
    localparam logic [6:0] SGR_ITALIC_OFF    = 7'd23;
    localparam logic [6:0] SGR_UNDERLINE_OFF = 7'd24;
    localparam logic [6:0] SGR_REVERSE_OFF   = 7'd27;
    localparam logic [6:0] SGR_FG_BASE       = 7'd30;
    localparam logic [6:0] SGR_DEFAULT       = 7'd39;
    localparam logic [6:0] SGR_BRIGHT_BASE   = 7'd90;
    localparam logic [6:0] SGR_BRIGHT_LOW    = 7'd82;   // bright base minus 8
    localparam logic [6:0] SGR_BG_OFFSET     = 7'd10;
    localparam logic [6:0] COLOR_NONE        = 7'd99;

    // Escape segment: up to eight bytes, sent in order from b[0]
    localparam int SEG_BYTES = 8;
    localparam int MAX_SEGS  = 3;

    typedef struct packed {
        logic [SEG_BYTES-1:0][7:0] b;
        logic [3:0]                len;
    } seg_t;

    // One queued command: the output of one accepted text byte
    typedef struct packed {
        seg_t [MAX_SEGS-1:0] seg;
        logic [1:0]          nseg;
        logic                last;
    } cmd_t;

    localparam int Q_DEPTH = 2;

    // Chat color number to 256-color terminal index
    localparam logic [7:0] PALETTE [99] = '{
        8'd15, 8'd0, 8'd4, 8'd2, 8'd9, 8'd1, 8'd5, 8'd3,
        8'd11, 8'd10, 8'd6, 8'd14, 8'd12, 8'd13, 8'd8, 8'd7,
        8'd52, 8'd94, 8'd100, 8'd58, 8'd22, 8'd29, 8'd23, 8'd24,
        8'd17, 8'd54, 8'd53, 8'd89, 8'd88, 8'd130, 8'd142, 8'd64,
        8'd28, 8'd35, 8'd30, 8'd25, 8'd18, 8'd91, 8'd90, 8'd125,
        8'd124, 8'd166, 8'd184, 8'd106, 8'd34, 8'd49, 8'd37, 8'd33,
        8'd19, 8'd129, 8'd127, 8'd161, 8'd196, 8'd208, 8'd226, 8'd154,
        8'd46, 8'd86, 8'd51, 8'd75, 8'd21, 8'd171, 8'd201, 8'd198,
        8'd203, 8'd215, 8'd227, 8'd191, 8'd83, 8'd122, 8'd87, 8'd111,
        8'd63, 8'd177, 8'd207, 8'd205, 8'd217, 8'd223, 8'd229, 8'd193,
        8'd157, 8'd158, 8'd159, 8'd153, 8'd147, 8'd183, 8'd219, 8'd212,
        8'd16, 8'd233, 8'd235, 8'd237, 8'd239, 8'd241, 8'd244, 8'd247,
        8'd250, 8'd254, 8'd231
    };

    // Color number to foreground SGR code
    function automatic logic [6:0] ansi_code(input logic [6:0] num);
        logic [7:0] c;
        logic [6:0] code;
        c = 8'd0;
        if (num >= COLOR_NONE) begin
            code = SGR_DEFAULT;
        end else begin
            c = PALETTE[num];
            if (c != 8'd0 && c[3:0] == 4'd0) begin
                code = SGR_BRIGHT_BASE;
            end else if (!c[3]) begin
                code = SGR_FG_BASE + 7'(c[2:0]);
            end else begin
                code = SGR_BRIGHT_LOW + 7'(c[3:0]);
            end
        end
        return code;
    endfunction

    // ESC [ value m, value below 128
    function automatic seg_t seg_esc(input logic [6:0] v);
        seg_t        s;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        s    = '0;
        r    = (v >= 7'd100) ? v - 7'd100 : v;
        // r / 10 by reciprocal, exact for r below 100
        prod = 15'(r) * 15'd205;
        t    = prod[14:11];
        o    = 4'(r - 7'(t) * 7'd10);
        s.b[0] = CH_ESC;
        s.b[1] = CH_LBRACK;
        if (v >= 7'd100) begin
            s.b[2] = CH_DIGIT1;
            s.b[3] = {4'h3, t};
            s.b[4] = {4'h3, o};
            s.b[5] = CH_M;
            s.len  = 4'd6;
        end else if (v >= 7'd10) begin
            s.b[2] = {4'h3, t};
            s.b[3] = {4'h3, o};
            s.b[4] = CH_M;
            s.len  = 4'd5;
        end else begin
            s.b[2] = {4'h3, o};
            s.b[3] = CH_M;
            s.len  = 4'd4;
        end
        return s;
    endfunction

    // ESC [ 3 9 ; 4 9 m
    function automatic seg_t seg_defclr();
        seg_t s;
        s      = '0;
        s.b[0] = CH_ESC;
        s.b[1] = CH_LBRACK;
        s.b[2] = CH_DIGIT3;
        s.b[3] = CH_DIGIT9;
        s.b[4] = CH_SEMI;
        s.b[5] = CH_DIGIT4;
        s.b[6] = CH_DIGIT9;
        s.b[7] = CH_M;
        s.len  = 4'd8;
        return s;
    endfunction

    // ESC [ m
    function automatic seg_t seg_reset();
        seg_t s;
        s      = '0;
        s.b[0] = CH_ESC;
        s.b[1] = CH_LBRACK;
        s.b[2] = CH_M;
        s.len  = 4'd3;
        return s;
    endfunction

    // Single text byte
    function automatic seg_t seg_byte(input logic [7:0] c);
        seg_t s;
        s      = '0;
        s.b[0] = c;
        s.len  = 4'd1;
        return s;
    endfunction

endpackage

// ===== hdl/irc_fmt_front.sv =====
`include "irc_format_to_ansi_escape_assert.svh"

module irc_fmt_front
    import irc_fmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  irc_in_t item,
    output logic    push_valid,
    input  logic    push_ready,
    output cmd_t    push_data
);

    phase_t     phase_reg, phase_next;
    logic [3:0] digit_reg, digit_next;
    logic       bold_reg, bold_next;
    logic       italic_reg, italic_next;
    logic       under_reg, under_next;
    logic       rev_reg, rev_next;

    logic                accept;
    logic [7:0]          b;
    logic                is_dig;
    logic [3:0]          d;
    logic [6:0]          num_two;
    logic [6:0]          num;
    logic [6:0]          code;
    logic [6:0]          code_bg;
    logic                do_plain;
    seg_t [MAX_SEGS-1:0] segs;
    logic [1:0]          n;

    assign item_ready = push_ready;
    assign accept     = item_valid && push_ready;
    assign b          = item.text_byte;
    assign is_dig     = (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
    assign d          = b[3:0];

    // Color lookup: a pending digit pair, a single held digit, or a fresh digit flushed at end of text
    assign num_two = 7'(digit_reg) * 7'd10 + 7'(d);
    always_comb
    begin
        if (phase_reg == PH_FG1 || phase_reg == PH_BG1)
        begin
            num = is_dig ? num_two : 7'(digit_reg);
        end
        else
        begin
            num = 7'(d);
        end
    end
    assign code    = ansi_code(num);
    assign code_bg = code + SGR_BG_OFFSET;

    // Classify the byte and build its segment list
    always_comb
    begin
        phase_next  = phase_reg;
        digit_next  = digit_reg;
        bold_next   = bold_reg;
        italic_next = italic_reg;
        under_next  = under_reg;
        rev_next    = rev_reg;
        segs        = '0;
        n           = 2'd0;
        do_plain    = 1'b0;

        unique case (phase_reg)
            PH_COLOR:
            begin
                if (is_dig)
                begin
                    digit_next = d;
                    phase_next = PH_FG1;
                end
                else
                begin
                    segs[n]    = seg_defclr();
                    n          = n + 2'd1;
                    phase_next = PH_PLAIN;
                    do_plain   = 1'b1;
                end
            end
            PH_FG1:
            begin
                segs[n] = seg_esc(code);
                n       = n + 2'd1;
                if (is_dig)
                begin
                    phase_next = PH_AFTER_FG;
                end
                else if (b == CH_COMMA)
                begin
                    phase_next = PH_COMMA;
                end
                else
                begin
                    phase_next = PH_PLAIN;
                    do_plain   = 1'b1;
                end
            end
            PH_AFTER_FG:
            begin
                if (b == CH_COMMA)
                begin
                    phase_next = PH_COMMA;
                end
                else
                begin
                    phase_next = PH_PLAIN;
                    do_plain   = 1'b1;
                end
            end
            PH_COMMA:
            begin
                if (is_dig)
                begin
                    digit_next = d;
                    phase_next = PH_BG1;
                end
                else
                begin
                    segs[n]    = seg_byte(CH_COMMA);
                    n          = n + 2'd1;
                    phase_next = PH_PLAIN;
                    do_plain   = 1'b1;
                end
            end
            PH_BG1:
            begin
                segs[n]    = seg_esc(code_bg);
                n          = n + 2'd1;
                phase_next = PH_PLAIN;
                do_plain   = !is_dig;
            end
            default:
            begin
                phase_next = PH_PLAIN;
                do_plain   = 1'b1;
            end
        endcase

        // Ordinary text or formatting code
        if (do_plain)
        begin
            unique case (b)
                CH_BOLD:
                begin
                    bold_next = !bold_reg;
                    segs[n]   = seg_esc(bold_next ? SGR_BOLD : SGR_BOLD_OFF);
                    n         = n + 2'd1;
                end
                CH_REVERSE:
                begin
                    rev_next = !rev_reg;
                    segs[n]  = seg_esc(rev_next ? SGR_REVERSE : SGR_REVERSE_OFF);
                    n        = n + 2'd1;
                end
                CH_ITALIC:
                begin
                    italic_next = !italic_reg;
                    segs[n]     = seg_esc(italic_next ? SGR_ITALIC : SGR_ITALIC_OFF);
                    n           = n + 2'd1;
                end
                CH_UNDERLINE:
                begin
                    under_next = !under_reg;
                    segs[n]    = seg_esc(under_next ? SGR_UNDERLINE : SGR_UNDERLINE_OFF);
                    n          = n + 2'd1;
                end
                CH_RESET:
                begin
                    segs[n]     = seg_reset();
                    n           = n + 2'd1;
                    bold_next   = 1'b0;
                    italic_next = 1'b0;
                    under_next  = 1'b0;
                    rev_next    = 1'b0;
                end
                CH_COLOR:
                begin
                    phase_next = PH_COLOR;
                end
                default:
                begin
                    segs[n] = seg_byte(b);
                    n       = n + 2'd1;
                end
            endcase
        end

        // End of text: flush what is pending, close with a reset
        if (item.end_of_text)
        begin
            case (phase_next)
                PH_COLOR:
                begin
                    segs[n] = seg_defclr();
                    n       = n + 2'd1;
                end
                PH_FG1:
                begin
                    segs[n] = seg_esc(code);
                    n       = n + 2'd1;
                end
                PH_COMMA:
                begin
                    segs[n] = seg_byte(CH_COMMA);
                    n       = n + 2'd1;
                end
                PH_BG1:
                begin
                    segs[n] = seg_esc(code_bg);
                    n       = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            segs[n]     = seg_reset();
            n           = n + 2'd1;
            phase_next  = PH_PLAIN;
            digit_next  = 4'd0;
            bold_next   = 1'b0;
            italic_next = 1'b0;
            under_next  = 1'b0;
            rev_next    = 1'b0;
        end
    end

    assign push_valid     = accept && (n != 2'd0);
    assign push_data.seg  = segs;
    assign push_data.nseg = n;
    assign push_data.last = item.end_of_text;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLAIN;
            digit_reg  <= 4'd0;
            bold_reg   <= 1'b0;
            italic_reg <= 1'b0;
            under_reg  <= 1'b0;
            rev_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            digit_reg  <= digit_next;
            bold_reg   <= bold_next;
            italic_reg <= italic_next;
            under_reg  <= under_next;
            rev_reg    <= rev_next;
        end
    end

    `IRC_ASSERT_NEXT(a_end_clears_state, accept && item.end_of_text, phase_reg == PH_PLAIN && !bold_reg && !italic_reg && !under_reg && !rev_reg, "end of text left parser state set")
    `IRC_ASSERT_SAME(a_digit_range, 1'b1, digit_reg <= 4'd9, "held color digit out of range")

endmodule

// ===== hdl/irc_fmt_queue.sv =====
`include "irc_format_to_ansi_escape_assert.svh"

module irc_fmt_queue
    import irc_fmt_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IRC_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue fill count overflow")
    `IRC_ASSERT_SAME(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")

endmodule

// ===== hdl/irc_fmt_back.sv =====
`include "irc_format_to_ansi_escape_assert.svh"

module irc_fmt_back
    import irc_fmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  cmd_t     head_data,
    output logic     pop,
    output logic     result_valid,
    input  logic     result_ready,
    output irc_out_t result
);

    logic [1:0] seg_idx_reg, seg_idx_next;
    logic [2:0] byte_idx_reg, byte_idx_next;
    logic       out_valid_reg, out_valid_next;
    irc_out_t   out_reg, out_next;

    seg_t cur;
    logic advance;
    logic end_seg;
    logic end_cmd;

    assign cur     = head_data.seg[seg_idx_reg];
    assign end_seg = ({1'b0, byte_idx_reg} == cur.len - 4'd1);
    assign end_cmd = end_seg && (seg_idx_reg == head_data.nseg - 2'd1);
    assign advance = head_valid && (!out_valid_reg || result_ready);
    assign pop     = advance && end_cmd;

    // Walk segments and bytes of the head command
    always_comb
    begin
        seg_idx_next   = seg_idx_reg;
        byte_idx_next  = byte_idx_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next    = 1'b1;
            out_next.out_byte = cur.b[byte_idx_reg];
            out_next.out_last = head_data.last && end_cmd;
            if (end_cmd)
            begin
                seg_idx_next  = 2'd0;
                byte_idx_next = 3'd0;
            end
            else if (end_seg)
            begin
                seg_idx_next  = seg_idx_reg + 2'd1;
                byte_idx_next = 3'd0;
            end
            else
            begin
                byte_idx_next = byte_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_idx_reg   <= 2'd0;
            byte_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_idx_reg   <= seg_idx_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `IRC_ASSERT_SAME(a_last_is_m, out_valid_reg && out_reg.out_last, out_reg.out_byte == CH_M, "closing byte is not the reset terminator")
    `IRC_ASSERT_SAME(a_seg_in_range, head_valid, seg_idx_reg < head_data.nseg, "segment index past command end")

endmodule

// ===== hdl/irc_format_to_ansi_escape.sv =====
// Chat formatting to ANSI escape translator. Text bytes enter on the item
// channel, one per transfer; translated bytes leave on the result channel,
// one per transfer, with out_last high on the final 'm' of the closing ESC[m
// after a byte marked end_of_text. The front end parses one byte per cycle
// while the queue has room and turns it into up to three output segments
// (plain byte, SGR escape, default color escape, reset); a command queue of
// QUEUE_DEPTH entries sits between it and the back end, which sends one
// output byte per cycle unless result_ready holds it. A byte expands into at
// most 19 output bytes (a color code with no digit followed by another color
// code at end of text); the input stalls only once the queue is full. The
// first output byte of a transfer passes through the queue entry and the
// back end's output register before it is offered on the result channel.
module irc_format_to_ansi_escape
    import irc_fmt_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  irc_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output irc_out_t result
);

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop;
    logic head_valid;
    cmd_t head_data;

    // Byte parser
    irc_fmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Command queue
    irc_fmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Byte emitter
    irc_fmt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
